// File: rtl/core/ffa_pkg.sv
// Package for the first-fit free-list allocator: shared constants,
// payload structs, controller states and datapath command/status types.
// No dependencies.
`timescale 1ns / 1ps

package ffa_pkg;

   // Default sizing, handed down from the top level
   localparam int HEAP_UNITS_DEF = 4096;
   localparam int UNIT_BYTES_DEF = 8;

   // Fixed field widths
   localparam int ARENA_W = 13;   // arena size register
   localparam int BYTES_W = 16;   // request size in bytes
   localparam int ADDR_W  = 12;   // payload unit index on the ports
   localparam int UNITS_W = 16;   // request size in units, header included
   localparam int DIV_W   = 17;   // operand width of the unit conversion

   typedef struct packed {
      logic               action;
      logic [BYTES_W-1:0] request_bytes;
      logic [ADDR_W-1:0]  block_address;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] payload_address;
   } rsp_type;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DIV,
      S_A_HEAD,
      S_A_FIRST,
      S_A_CHK,
      S_A_TAIL,
      S_F_EMPTY,
      S_F_HEAD,
      S_F_CHK,
      S_F_BP,
      S_F_N,
      S_F_P,
      S_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CFG,
      OP_INIT,
      OP_ACCEPT,
      OP_DIV,
      OP_A_HEAD,
      OP_A_FIRST,
      OP_A_EXACT,
      OP_A_SPLIT,
      OP_A_NEXT,
      OP_A_TAIL,
      OP_F_EMPTY,
      OP_F_HEAD,
      OP_F_NEXT,
      OP_F_FOUND,
      OP_F_BP,
      OP_F_N,
      OP_F_P,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_ctrl_type;

   typedef struct packed {
      logic div_last;    // final conversion step this cycle
      logic is_free;     // current item is a free
      logic empty;       // free list holds no block
      logic fit;         // block at p is large enough
      logic exact;       // block at p matches exactly
      logic at_head;     // walk is back at the roving head
      logic step_last;   // walk step limit reached
      logic found;       // insertion point for a free located
      logic rsp_free;    // output register can take a result
   } dp_stat_type;

endpackage

// File: rtl/core/first_fit_free_list_allocator.sv
// First-fit free-list heap allocator, searching from a roving head. Controller plus datapath.
// Depends on ffa_pkg, ffa_ctrl and ffa_dpath.
// Usage:
//  - req channel (req_valid/req_ready/req_data): one allocate or free per
//    transfer. rsp channel (rsp_valid/rsp_ready/rsp_data): one result per
//    request, in order. csr channel (csr_valid/csr_ready/csr_data): writes
//    the arena size and rebuilds the arena as one free block.
//  - Operation: a reciprocal multiply, quotient first and then remainder,
//    turns bytes into units (or the payload index into a header index),
//    then the list is walked one free block per cycle. A split also writes
//    the tail header; a free also reads the freed block and its successor
//    and writes the merges; an empty list skips the walk. One request is
//    in work at a time; the next is taken in the cycle after its
//    predecessor's result is posted.
//  - Reset: S_INIT writes the initial block header, then the block is ready.
//    A csr write also passes through S_INIT to rebuild the arena.
//  - If the receiver stalls, a finished result waits in the output
//    register; the next request is accepted and worked meanwhile, and its
//    result is held back until the register frees up.
`timescale 1ns / 1ps

module first_fit_free_list_allocator import ffa_pkg::*; #(
   parameter int HEAP_UNITS = HEAP_UNITS_DEF,
   parameter int UNIT_BYTES = UNIT_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [ARENA_W-1:0] csr_data
);

   dp_ctrl_type ctl;
   dp_stat_type stat;

   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   ffa_dpath #(
      .HEAP_UNITS (HEAP_UNITS),
      .UNIT_BYTES (UNIT_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_data  (req_data),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

// File: rtl/core/ffa_dpath.sv
// Datapath of the allocator: header memories, walk pointers, reciprocal
// unit conversion and the result output register. Driven by ffa_ctrl
// commands. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_dpath import ffa_pkg::*; #(
   parameter int HEAP_UNITS = HEAP_UNITS_DEF,
   parameter int UNIT_BYTES = UNIT_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_ctrl_type        ctl,
   output dp_stat_type        stat,
   input  req_type            req_data,
   input  logic [ARENA_W-1:0] csr_data,
   output rsp_type            rsp_data,
   output logic               rsp_valid,
   input  logic               rsp_ready
);

   localparam int IW = $clog2(HEAP_UNITS);
   localparam int SW = $clog2(HEAP_UNITS + 1);
   localparam int CW = ((SW > UNITS_W) ? SW : UNITS_W) + 1;
   localparam int CLW = ((SW > ARENA_W) ? SW : ARENA_W) + 1;
   localparam logic [DIV_W-1:0] HEAP_DIV = DIV_W'(HEAP_UNITS);
   localparam logic [DIV_W-1:0] UB_DIV = DIV_W'(UNIT_BYTES);
   localparam logic [SW-1:0] ARENA_RST = SW'((HEAP_UNITS < 4096) ? HEAP_UNITS : 4096);
   localparam logic [SW:0] HEAP_SUM = (SW+1)'(HEAP_UNITS);

   // reciprocals: floor(x / d) = (x * ceil(2^s / d)) >> s for x below 2^DIV_W
   localparam int RCP_W = DIV_W + 2;
   localparam int PRD_W = DIV_W + RCP_W;
   localparam int UB_SH = DIV_W + $clog2(UNIT_BYTES);
   localparam int HP_SH = DIV_W + $clog2(HEAP_UNITS);
   localparam longint UB_RCP = ((longint'(1) << UB_SH) + UNIT_BYTES - 1) / UNIT_BYTES;
   localparam longint HP_RCP = ((longint'(1) << HP_SH) + HEAP_UNITS - 1) / HEAP_UNITS;
   localparam logic [RCP_W-1:0] UB_M = RCP_W'(UB_RCP);
   localparam logic [RCP_W-1:0] HP_M = RCP_W'(HP_RCP);

   // wrap a small sum of unit indices back into the index range 0 .. HEAP_UNITS-1
   function automatic logic [IW-1:0] wrap_sum(input logic [SW:0] s);
      logic [SW:0] r;
      r = (s >= HEAP_SUM) ? (s - HEAP_SUM) : s;
      return r[IW-1:0];
   endfunction

   // header memories
   logic [SW-1:0] size_mem [HEAP_UNITS];
   logic [IW-1:0] link_mem [HEAP_UNITS];
   logic [SW-1:0] size_q_ff;
   logic [IW-1:0] link_q_ff;
   logic          size_we, link_we;
   logic [IW-1:0] wr_addr, rd_addr, link_wd;
   logic [SW-1:0] size_wd;

   // registers
   logic [SW-1:0]      arena_ff, arena_in;
   logic [IW-1:0]      head_ff, head_in;
   logic               empty_ff, empty_in;
   logic               act_ff, act_in;
   logic [IW-1:0]      p_ff, p_in;
   logic [IW-1:0]      prev_ff, prev_in;
   logic [IW-1:0]      n_ff, n_in;
   logic [IW-1:0]      q_ff, q_in;
   logic [SW-1:0]      psize_ff, psize_in;
   logic [SW-1:0]      bsize_ff, bsize_in;
   logic [SW-1:0]      nbsize_ff, nbsize_in;
   logic [IW-1:0]      nblink_ff, nblink_in;
   logic [SW-1:0]      step_ff, step_in;
   logic [DIV_W-1:0]   num_ff, num_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic               dcnt_ff, dcnt_in;
   logic               res_ok_ff, res_ok_in;
   logic [ADDR_W-1:0]  res_pay_ff, res_pay_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // derived values
   logic [UNITS_W-1:0] units_w;
   logic [IW-1:0]      bp_w;
   logic [PRD_W-1:0]   ub_prd_w, hp_prd_w;
   logic [DIV_W-1:0]   quot_w;
   logic [DIV_W-1:0]   back_w;
   logic [SW-1:0]      newsize_w;
   logic [IW-1:0]      q_w;
   logic [BYTES_W-1:0] bytes_w;
   logic [SW:0]        clamp_w;
   logic               merge_next_w, merge_prev_w;

   // quotient and remainder stay in num and rem after the last step
   assign units_w   = UNITS_W'(num_ff) + UNITS_W'(1);
   assign bp_w      = rem_ff[IW-1:0];
   assign ub_prd_w  = PRD_W'(num_ff) * PRD_W'(UB_M);
   assign hp_prd_w  = PRD_W'(num_ff) * PRD_W'(HP_M);
   assign quot_w    = act_ff ? DIV_W'(hp_prd_w >> HP_SH) : DIV_W'(ub_prd_w >> UB_SH);
   assign back_w    = act_ff ? DIV_W'(num_ff * HEAP_DIV) : DIV_W'(num_ff * UB_DIV);
   assign newsize_w = size_q_ff - SW'(units_w);
   assign q_w       = wrap_sum((SW+1)'(p_ff) + (SW+1)'(newsize_w));
   assign bytes_w   = (req_data.request_bytes == '0) ? BYTES_W'(1) : req_data.request_bytes;
   assign merge_next_w = ((SW+1)'(bp_w) + (SW+1)'(bsize_ff)) == (SW+1)'(n_ff);
   assign merge_prev_w = ((SW+1)'(p_ff) + (SW+1)'(psize_ff)) == (SW+1)'(bp_w);

   // register clamp to the range 2 .. HEAP_UNITS
   always_comb begin
      clamp_w = (SW+1)'(csr_data);
      if ((ARENA_W+1)'(csr_data) < (ARENA_W+1)'(2)) begin
         clamp_w = (SW+1)'(2);
      end else if (CLW'(csr_data) > CLW'(HEAP_UNITS)) begin
         clamp_w = HEAP_SUM;
      end
   end

   // status to the controller
   always_comb begin
      stat.div_last  = dcnt_ff;
      stat.is_free   = act_ff;
      stat.empty     = empty_ff;
      stat.fit       = CW'(size_q_ff) >= CW'(units_w);
      stat.exact     = CW'(size_q_ff) == CW'(units_w);
      stat.at_head   = (p_ff == head_ff);
      stat.step_last = (step_ff == SW'(HEAP_UNITS));
      stat.found     = ((bp_w > p_ff) && (bp_w < link_q_ff)) ||
                       ((p_ff >= link_q_ff) && ((bp_w > p_ff) || (bp_w < link_q_ff)));
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // command decode
   always_comb begin
      arena_in   = arena_ff;
      head_in    = head_ff;
      empty_in   = empty_ff;
      act_in     = act_ff;
      p_in       = p_ff;
      prev_in    = prev_ff;
      n_in       = n_ff;
      q_in       = q_ff;
      psize_in   = psize_ff;
      bsize_in   = bsize_ff;
      nbsize_in  = nbsize_ff;
      nblink_in  = nblink_ff;
      step_in    = step_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      dcnt_in    = dcnt_ff;
      res_ok_in  = res_ok_ff;
      res_pay_in = res_pay_ff;
      rsp_in     = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      size_we = 1'b0;
      link_we = 1'b0;
      wr_addr = p_ff;
      size_wd = '0;
      link_wd = '0;
      rd_addr = p_ff;
      case (ctl.op)
         OP_CFG: begin
            arena_in = SW'(clamp_w);
         end
         OP_INIT: begin
            wr_addr  = '0;
            size_we  = 1'b1;
            size_wd  = arena_ff;
            link_we  = 1'b1;
            link_wd  = '0;
            head_in  = '0;
            empty_in = 1'b0;
         end
         OP_ACCEPT: begin
            act_in = req_data.action;
            if (req_data.action == ACT_FREE) begin
               num_in = DIV_W'(req_data.block_address) + DIV_W'(HEAP_UNITS - 1);
            end else begin
               num_in = DIV_W'(bytes_w) + DIV_W'(UNIT_BYTES - 1);
            end
            rem_in     = '0;
            dcnt_in    = 1'b0;
            res_ok_in  = 1'b0;
            res_pay_in = '0;
         end
         OP_DIV: begin
            // first step: quotient into num, operand kept in rem
            // second step: remainder into rem
            if (!dcnt_ff) begin
               num_in = quot_w;
               rem_in = num_ff;
            end else begin
               rem_in = rem_ff - back_w;
            end
            dcnt_in = 1'b1;
         end
         OP_A_HEAD: begin
            rd_addr = head_ff;
            prev_in = head_ff;
            step_in = '0;
         end
         OP_A_FIRST: begin
            p_in    = link_q_ff;
            rd_addr = link_q_ff;
         end
         OP_A_EXACT: begin
            // unlink the block, or empty the list if it was the only one
            if (p_ff == prev_ff) begin
               empty_in = 1'b1;
            end else begin
               wr_addr = prev_ff;
               link_we = 1'b1;
               link_wd = link_q_ff;
            end
            head_in    = prev_ff;
            res_ok_in  = 1'b1;
            res_pay_in = ADDR_W'(wrap_sum((SW+1)'(p_ff) + (SW+1)'(1)));
         end
         OP_A_SPLIT: begin
            // shrink the block and carve its tail
            wr_addr    = p_ff;
            size_we    = 1'b1;
            size_wd    = newsize_w;
            q_in       = q_w;
            head_in    = prev_ff;
            res_ok_in  = 1'b1;
            res_pay_in = ADDR_W'(wrap_sum((SW+1)'(q_w) + (SW+1)'(1)));
         end
         OP_A_NEXT: begin
            prev_in = p_ff;
            p_in    = link_q_ff;
            rd_addr = link_q_ff;
            step_in = step_ff + SW'(1);
         end
         OP_A_TAIL: begin
            wr_addr = q_ff;
            size_we = 1'b1;
            size_wd = SW'(units_w);
         end
         OP_F_EMPTY: begin
            wr_addr   = bp_w;
            link_we   = 1'b1;
            link_wd   = bp_w;
            head_in   = bp_w;
            empty_in  = 1'b0;
            res_ok_in = 1'b1;
         end
         OP_F_HEAD: begin
            p_in    = head_ff;
            rd_addr = head_ff;
            step_in = '0;
         end
         OP_F_NEXT: begin
            p_in    = link_q_ff;
            rd_addr = link_q_ff;
            step_in = step_ff + SW'(1);
         end
         OP_F_FOUND: begin
            psize_in = size_q_ff;
            n_in     = link_q_ff;
            rd_addr  = bp_w;
         end
         OP_F_BP: begin
            bsize_in = size_q_ff;
            rd_addr  = n_ff;
         end
         OP_F_N: begin
            // merge with the following free block when adjacent
            wr_addr = bp_w;
            link_we = 1'b1;
            if (merge_next_w) begin
               nbsize_in = bsize_ff + size_q_ff;
               nblink_in = link_q_ff;
               size_we   = 1'b1;
               size_wd   = bsize_ff + size_q_ff;
               link_wd   = link_q_ff;
            end else begin
               nbsize_in = bsize_ff;
               nblink_in = n_ff;
               link_wd   = n_ff;
            end
         end
         OP_F_P: begin
            // merge into the preceding free block when adjacent
            wr_addr = p_ff;
            link_we = 1'b1;
            if (merge_prev_w) begin
               size_we = 1'b1;
               size_wd = psize_ff + nbsize_ff;
               link_wd = nblink_ff;
            end else begin
               link_wd = bp_w;
            end
            head_in   = p_ff;
            res_ok_in = 1'b1;
         end
         OP_PUBLISH: begin
            rsp_in.ok              = res_ok_ff;
            rsp_in.payload_address = res_pay_ff;
            rsp_valid_in           = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // header memories, registered read
   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[wr_addr] <= size_wd;
      end
      if (link_we) begin
         link_mem[wr_addr] <= link_wd;
      end
      size_q_ff <= size_mem[rd_addr];
      link_q_ff <= link_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         arena_ff     <= ARENA_RST;
         head_ff      <= '0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         arena_ff     <= arena_in;
         head_ff      <= head_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      p_ff       <= p_in;
      prev_ff    <= prev_in;
      n_ff       <= n_in;
      q_ff       <= q_in;
      psize_ff   <= psize_in;
      bsize_ff   <= bsize_in;
      nbsize_ff  <= nbsize_in;
      nblink_ff  <= nblink_in;
      step_ff    <= step_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      dcnt_ff    <= dcnt_in;
      res_ok_ff  <= res_ok_in;
      res_pay_ff <= res_pay_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/ffa_ctrl.sv
// Controller state machine of the allocator: sequences the divider, the
// list walk and the header updates. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_ctrl import ffa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  dp_stat_type stat,
   output dp_ctrl_type ctl
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (csr_valid) begin
               state_in = S_INIT;
            end else if (req_valid) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.div_last) begin
               if (stat.is_free) begin
                  state_in = stat.empty ? S_F_EMPTY : S_F_HEAD;
               end else begin
                  state_in = stat.empty ? S_FINISH : S_A_HEAD;
               end
            end
         end
         S_A_HEAD: begin
            state_in = S_A_FIRST;
         end
         S_A_FIRST: begin
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            if (stat.fit && stat.exact) begin
               state_in = S_FINISH;
            end else if (stat.fit) begin
               state_in = S_A_TAIL;
            end else if (stat.at_head || stat.step_last) begin
               state_in = S_FINISH;
            end
         end
         S_A_TAIL: begin
            state_in = S_FINISH;
         end
         S_F_EMPTY: begin
            state_in = S_FINISH;
         end
         S_F_HEAD: begin
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            if (stat.found) begin
               state_in = S_F_BP;
            end else if (stat.step_last) begin
               state_in = S_FINISH;
            end
         end
         S_F_BP: begin
            state_in = S_F_N;
         end
         S_F_N: begin
            state_in = S_F_P;
         end
         S_F_P: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      csr_ready = 1'b0;
      ctl.op    = OP_NONE;
      case (state_ff)
         S_INIT: begin
            ctl.op = OP_INIT;
         end
         S_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (csr_valid) begin
               ctl.op = OP_CFG;
            end else if (req_valid) begin
               ctl.op = OP_ACCEPT;
            end
         end
         S_DIV: begin
            ctl.op = OP_DIV;
         end
         S_A_HEAD: begin
            ctl.op = OP_A_HEAD;
         end
         S_A_FIRST: begin
            ctl.op = OP_A_FIRST;
         end
         S_A_CHK: begin
            if (stat.fit && stat.exact) begin
               ctl.op = OP_A_EXACT;
            end else if (stat.fit) begin
               ctl.op = OP_A_SPLIT;
            end else if (!(stat.at_head || stat.step_last)) begin
               ctl.op = OP_A_NEXT;
            end
         end
         S_A_TAIL: begin
            ctl.op = OP_A_TAIL;
         end
         S_F_EMPTY: begin
            ctl.op = OP_F_EMPTY;
         end
         S_F_HEAD: begin
            ctl.op = OP_F_HEAD;
         end
         S_F_CHK: begin
            if (stat.found) begin
               ctl.op = OP_F_FOUND;
            end else if (!stat.step_last) begin
               ctl.op = OP_F_NEXT;
            end
         end
         S_F_BP: begin
            ctl.op = OP_F_BP;
         end
         S_F_N: begin
            ctl.op = OP_F_N;
         end
         S_F_P: begin
            ctl.op = OP_F_P;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               ctl.op = OP_PUBLISH;
            end
         end
         default: begin
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
